[rtl/core/met_pkg.sv]
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and helpers of the escape-time pixel unit.
// ----------------------------------------------------------------------------
package met_pkg;

   localparam int FRAC_BITS_DEF = 28;
   localparam int SIDE_BITS_DEF = 10;
   localparam int ITER_BITS_DEF = 16;

   localparam int WORD_W   = 32;
   localparam int SAT_W    = 66;
   localparam int WIDTH_W  = 11;
   localparam int STEP_W   = 31;
   localparam int LIMIT_W  = 16;
   localparam int OUT_IT_W = 16;
   localparam int COLOR_W  = 3;

   localparam logic [COLOR_W-1:0] COLOR_INSIDE = 3'd6;
   localparam logic [COLOR_W-1:0] COLOR_LAST   = 3'd5;

   localparam int QUEUE_DEPTH = 2;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_CENTER     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_CENTER     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER     = 3'd5;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [WIDTH_W-1:0]        image_width;
      logic [WIDTH_W-1:0]        image_height;
      logic [STEP_W-1:0]         step;
      logic signed [WORD_W-1:0]  x_center;
      logic signed [WORD_W-1:0]  y_center;
      logic [LIMIT_W-1:0]        max_iterations;
   } cfg_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] cr;
      logic signed [WORD_W-1:0] ci;
      logic                     inside_now;
   } point_type;

   typedef struct packed {
      logic                 empty;
      logic [CNT_W-1:0]     count;
   } queue_status_type;

   typedef struct packed {
      logic                 valid;
      logic                 escaped;
      logic [OUT_IT_W-1:0]  iterations;
      logic [COLOR_W-1:0]   color;
   } rsp_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_UPD
   } back_state_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > SAT_W'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < SAT_W'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/met_csr.sv]
// ----------------------------------------------------------------------------
// met_csr
// Configuration registers behind an APB-style port, read back in place.
// ----------------------------------------------------------------------------
module met_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [met_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [met_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [met_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output met_pkg::cfg_type                   cfg
);

   met_pkg::cfg_type                  cfg_ff;
   met_pkg::cfg_type                  cfg_in;
   logic [met_pkg::CSR_IDX_W-1:0]     index;
   logic                              wr_en;

   assign index      = csr_paddr[met_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            met_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_pwdata[met_pkg::WIDTH_W-1:0];
            met_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr_pwdata[met_pkg::WIDTH_W-1:0];
            met_pkg::REG_STEP:         cfg_in.step         = csr_pwdata[met_pkg::STEP_W-1:0];
            met_pkg::REG_X_CENTER:     cfg_in.x_center     = csr_pwdata;
            met_pkg::REG_Y_CENTER:     cfg_in.y_center     = csr_pwdata;
            met_pkg::REG_MAX_ITER:     cfg_in.max_iterations = csr_pwdata[met_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         met_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(cfg_ff.image_width);
         met_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(cfg_ff.image_height);
         met_pkg::REG_STEP:         csr_prdata = 32'(cfg_ff.step);
         met_pkg::REG_X_CENTER:     csr_prdata = cfg_ff.x_center;
         met_pkg::REG_Y_CENTER:     csr_prdata = cfg_ff.y_center;
         met_pkg::REG_MAX_ITER:     csr_prdata = 32'(cfg_ff.max_iterations);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= 11'd80;
         cfg_ff.image_height   <= 11'd24;
         cfg_ff.step           <= 31'd13421773;
         cfg_ff.x_center       <= '0;
         cfg_ff.y_center       <= '0;
         cfg_ff.max_iterations <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/met_front.sv]
// ----------------------------------------------------------------------------
// met_front
// Takes pixel commands, maps row and column to the point c and tags
// points with a zero iteration limit, then pushes them to the queue.
// ----------------------------------------------------------------------------
module met_front #(
   parameter int SIDE_BITS = met_pkg::SIDE_BITS_DEF,
   parameter int ITER_BITS = met_pkg::ITER_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [SIDE_BITS-1:0]        row,
   input  logic [SIDE_BITS-1:0]        col,
   input  met_pkg::cfg_type            cfg,
   input  met_pkg::queue_status_type   qstat,
   output logic                        push,
   output met_pkg::point_type          push_data
);

   localparam int SW0 = (SIDE_BITS + 1 > met_pkg::WIDTH_W) ? SIDE_BITS + 1 : met_pkg::WIDTH_W;
   localparam int DW  = SW0 + 2;
   localparam int PW  = DW + met_pkg::WORD_W;
   localparam int IW  = met_pkg::CNT_W + 1;

   logic                   accept;
   logic [IW-1:0]          inflight;
   logic [DW-1:0]          col_x2;
   logic [DW-1:0]          row_x2;
   logic [DW-1:0]          wd;
   logic [DW-1:0]          hd;
   logic                   s1_valid_ff;
   logic signed [DW-1:0]   dx_ff;
   logic signed [DW-1:0]   dy_ff;
   logic signed [DW-1:0]   dx_in;
   logic signed [DW-1:0]   dy_in;
   logic                   s2_valid_ff;
   logic signed [PW-1:0]   hx_ff;
   logic signed [PW-1:0]   hy_ff;
   logic signed [PW-1:0]   hx_in;
   logic signed [PW-1:0]   hy_in;
   logic signed [PW-1:0]   step_s;
   logic signed [met_pkg::WORD_W-1:0] ci_half;
   logic [ITER_BITS+met_pkg::LIMIT_W-1:0] limit_x;

   // credits: items in the front pipe plus queued ones never exceed the queue
   assign inflight = IW'(s1_valid_ff) + IW'(s2_valid_ff) + IW'(qstat.count);
   assign busy     = inflight >= IW'(met_pkg::QUEUE_DEPTH);
   assign accept   = start & ~busy;

   assign col_x2 = {{(DW-SIDE_BITS-1){1'b0}}, col, 1'b0};
   assign row_x2 = {{(DW-SIDE_BITS-1){1'b0}}, row, 1'b0};
   assign wd     = {{(DW-met_pkg::WIDTH_W){1'b0}}, cfg.image_width};
   assign hd     = {{(DW-met_pkg::WIDTH_W){1'b0}}, cfg.image_height};
   assign dx_in  = $signed(col_x2 - wd + DW'(1));
   assign dy_in  = $signed(hd - row_x2 - DW'(1));

   // offsets are kept in half pixels, then halved with floor
   assign step_s = $signed(PW'(cfg.step));
   assign hx_in  = (PW'(dx_ff) * step_s) >>> 1;
   assign hy_in  = (PW'(dy_ff) * step_s) >>> 1;

   assign ci_half = met_pkg::sat_word(met_pkg::SAT_W'(hy_ff) + met_pkg::SAT_W'(cfg.y_center));
   assign limit_x = {{ITER_BITS{1'b0}}, cfg.max_iterations};

   assign push                 = s2_valid_ff;
   assign push_data.cr         = met_pkg::sat_word(met_pkg::SAT_W'(hx_ff)
                                                   + met_pkg::SAT_W'(cfg.x_center));
   assign push_data.ci         = met_pkg::sat_word(met_pkg::SAT_W'(ci_half)
                                                   + met_pkg::SAT_W'(ci_half));
   assign push_data.inside_now = (limit_x[ITER_BITS-1:0] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (s1_valid_ff) begin
         hx_ff <= hx_in;
         hy_ff <= hy_in;
      end
   end

endmodule

[rtl/core/met_queue.sv]
// ----------------------------------------------------------------------------
// met_queue
// Short first-in first-out queue of mapped points between front and back.
// ----------------------------------------------------------------------------
module met_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  met_pkg::point_type          push_data,
   input  logic                        pop,
   output met_pkg::point_type          head,
   output met_pkg::queue_status_type   qstat
);

   localparam int DEPTH = met_pkg::QUEUE_DEPTH;
   localparam int CW    = met_pkg::CNT_W;
   localparam int PW    = met_pkg::PTR_W;

   met_pkg::point_type   entry_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff;
   logic [PW-1:0]        wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff;
   logic [PW-1:0]        rd_ptr_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CW'(DEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

endmodule

[rtl/core/met_back.sv]
// ----------------------------------------------------------------------------
// met_back
// Iterates z = z*z + c for one point at a time: a multiply cycle forms the
// three truncated products, an update cycle tests escape and forms new z.
// ----------------------------------------------------------------------------
module met_back #(
   parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF,
   parameter int ITER_BITS = met_pkg::ITER_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  met_pkg::cfg_type            cfg,
   input  met_pkg::point_type          head,
   input  met_pkg::queue_status_type   qstat,
   output logic                        pop,
   output met_pkg::rsp_type            rsp
);

   localparam int WW  = met_pkg::WORD_W;
   localparam int PW2 = 2 * WW - FRAC_BITS;
   localparam int SW  = (PW2 + 1 > FRAC_BITS + 3) ? PW2 + 1 : FRAC_BITS + 3;
   localparam logic signed [SW-1:0] FOUR = SW'(4) <<< FRAC_BITS;

   met_pkg::back_state_type   state_ff;
   met_pkg::back_state_type   state_in;
   logic signed [WW-1:0]      cr_ff;
   logic signed [WW-1:0]      ci_ff;
   logic signed [WW-1:0]      zr_ff;
   logic signed [WW-1:0]      zi_ff;
   logic signed [WW-1:0]      zr_in;
   logic signed [WW-1:0]      zi_in;
   logic                      first_ff;
   logic                      first_in;
   logic [ITER_BITS-1:0]      k_ff;
   logic [ITER_BITS-1:0]      k_in;
   logic [met_pkg::COLOR_W-1:0] mod_ff;
   logic [met_pkg::COLOR_W-1:0] mod_in;
   logic signed [PW2-1:0]     prr_ff;
   logic signed [PW2-1:0]     pii_ff;
   logic signed [PW2-1:0]     pri_ff;
   logic signed [2*WW-1:0]    full_rr;
   logic signed [2*WW-1:0]    full_ii;
   logic signed [2*WW-1:0]    full_ri;
   logic signed [WW-1:0]      rr_s;
   logic signed [WW-1:0]      ii_s;
   logic signed [WW-1:0]      ri_s;
   logic signed [WW-1:0]      diff_s;
   logic signed [WW-1:0]      cross_s;
   logic signed [SW-1:0]      mag;
   logic                      escape;
   logic                      last;
   logic [ITER_BITS-1:0]      k_next;
   logic [ITER_BITS+met_pkg::LIMIT_W-1:0] limit_x;
   logic [ITER_BITS-1:0]      limit;
   logic [ITER_BITS+met_pkg::OUT_IT_W-1:0] k_x;
   met_pkg::rsp_type          rsp_ff;
   met_pkg::rsp_type          rsp_in;

   assign limit_x = {{ITER_BITS{1'b0}}, cfg.max_iterations};
   assign limit   = limit_x[ITER_BITS-1:0];
   assign k_x     = {{met_pkg::OUT_IT_W{1'b0}}, k_ff};
   assign k_next  = k_ff + ITER_BITS'(1);

   assign full_rr = 64'(zr_ff) * 64'(zr_ff);
   assign full_ii = 64'(zi_ff) * 64'(zi_ff);
   assign full_ri = 64'(zr_ff) * 64'(zi_ff);

   assign rr_s    = met_pkg::sat_word(met_pkg::SAT_W'(prr_ff));
   assign ii_s    = met_pkg::sat_word(met_pkg::SAT_W'(pii_ff));
   assign ri_s    = met_pkg::sat_word(met_pkg::SAT_W'(pri_ff));
   assign diff_s  = met_pkg::sat_word(met_pkg::SAT_W'(rr_s) - met_pkg::SAT_W'(ii_s));
   assign cross_s = met_pkg::sat_word(met_pkg::SAT_W'(ri_s) + met_pkg::SAT_W'(ri_s));
   assign zr_in   = met_pkg::sat_word(met_pkg::SAT_W'(diff_s) + met_pkg::SAT_W'(cr_ff));
   assign zi_in   = met_pkg::sat_word(met_pkg::SAT_W'(cross_s) + met_pkg::SAT_W'(ci_ff));

   // products in hand belong to the z of iteration k unless this is the first pass
   assign mag    = SW'(prr_ff) + SW'(pii_ff);
   assign escape = ~first_ff & (mag > FOUR);
   assign last   = ~first_ff & (k_next == limit);

   always_comb begin
      state_in          = state_ff;
      first_in          = first_ff;
      k_in              = k_ff;
      mod_in            = mod_ff;
      pop               = 1'b0;
      rsp_in            = rsp_ff;
      rsp_in.valid      = 1'b0;
      unique case (state_ff)
         met_pkg::BACK_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               first_in = 1'b1;
               k_in     = '0;
               mod_in   = '0;
               if (head.inside_now) begin
                  rsp_in.valid      = 1'b1;
                  rsp_in.escaped    = 1'b0;
                  rsp_in.iterations = '0;
                  rsp_in.color      = met_pkg::COLOR_INSIDE;
               end else begin
                  state_in = met_pkg::BACK_MUL;
               end
            end
         end
         met_pkg::BACK_MUL: begin
            state_in = met_pkg::BACK_UPD;
         end
         met_pkg::BACK_UPD: begin
            priority if (escape) begin
               rsp_in.valid      = 1'b1;
               rsp_in.escaped    = 1'b1;
               rsp_in.iterations = k_x[met_pkg::OUT_IT_W-1:0];
               rsp_in.color      = mod_ff;
               state_in          = met_pkg::BACK_IDLE;
            end else if (last) begin
               rsp_in.valid      = 1'b1;
               rsp_in.escaped    = 1'b0;
               rsp_in.iterations = '0;
               rsp_in.color      = met_pkg::COLOR_INSIDE;
               state_in          = met_pkg::BACK_IDLE;
            end else begin
               first_in = 1'b0;
               if (!first_ff) begin
                  k_in   = k_next;
                  mod_in = (mod_ff == met_pkg::COLOR_LAST) ? '0 : mod_ff + 3'd1;
               end
               state_in = met_pkg::BACK_MUL;
            end
         end
         default: state_in = met_pkg::BACK_IDLE;
      endcase
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= met_pkg::BACK_IDLE;
         rsp_ff   <= '0;
         first_ff <= 1'b0;
         k_ff     <= '0;
         mod_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
         first_ff <= first_in;
         k_ff     <= k_in;
         mod_ff   <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cr_ff <= head.cr;
         ci_ff <= head.ci;
         zr_ff <= head.cr;
         zi_ff <= head.ci;
      end else if (state_ff == met_pkg::BACK_UPD) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end
      if (state_ff == met_pkg::BACK_MUL) begin
         prr_ff <= PW2'(full_rr >>> FRAC_BITS);
         pii_ff <= PW2'(full_ii >>> FRAC_BITS);
         pri_ff <= PW2'(full_ri >>> FRAC_BITS);
      end
   end

   a_mul_then_upd: assert property (@(posedge clock) disable iff (reset)
      state_ff == met_pkg::BACK_MUL |=> state_ff == met_pkg::BACK_UPD)
      else $error("multiply cycle not followed by update");

   a_word_from_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> state_ff == met_pkg::BACK_IDLE)
      else $error("result word while a point is still iterating");

   a_escaped_color: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> (rsp_ff.escaped ? (rsp_ff.color <= met_pkg::COLOR_LAST)
                                       : (rsp_ff.color == met_pkg::COLOR_INSIDE
                                          && rsp_ff.iterations == '0)))
      else $error("color does not match escape flag");

endmodule

[rtl/core/mandelbrot_escape_time_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time pixel engine: maps a pixel to c and iterates z = z*z + c.
//
//   channel   ports                                      handshake
//   request   req_row, req_col                           start, busy
//   result    rsp_escaped, rsp_iterations, rsp_color     rsp_valid (1 cycle)
//   config    csr_psel/penable/pwrite/paddr/pwdata/...   apb, pready tied high
//
// The front maps a pixel through registers s1 and s2 and queues up to 2
// points; busy rises when front and queue together hold 2 points.
// The back iterates one point at a time, each iteration a multiply state
// then an update state; a zero-limit point is answered from the idle state.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset is synchronous and loads the default configuration.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit #(
   parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF,
   parameter int SIDE_BITS = met_pkg::SIDE_BITS_DEF,
   parameter int ITER_BITS = met_pkg::ITER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [SIDE_BITS-1:0]                req_row,
   input  logic [SIDE_BITS-1:0]                req_col,
   output logic                                rsp_valid,
   output logic                                rsp_escaped,
   output logic [met_pkg::OUT_IT_W-1:0]        rsp_iterations,
   output logic [met_pkg::COLOR_W-1:0]         rsp_color,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [met_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [met_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [met_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   met_pkg::cfg_type            cfg;
   met_pkg::queue_status_type   qstat;
   met_pkg::point_type          push_data;
   met_pkg::point_type          head;
   met_pkg::rsp_type            rsp;
   logic                        push;
   logic                        pop;

   met_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   met_front #(
      .SIDE_BITS (SIDE_BITS),
      .ITER_BITS (ITER_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .row       (req_row),
      .col       (req_col),
      .cfg       (cfg),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   met_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   met_back #(
      .FRAC_BITS (FRAC_BITS),
      .ITER_BITS (ITER_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_escaped    = rsp.escaped;
   assign rsp_iterations = rsp.iterations;
   assign rsp_color      = rsp.color;

endmodule
